// ===== rtl/sliding_window_median_macros.svh =====
// ----------------------------------------------------------------------------
// Sliding window median: assertion macros
// Shared assertion forms on clk; SWM_ASSERT is disabled by rst_n, active low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Checked on every edge outside reset.
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median: package
// Sizes, cell state types and constants shared by the block's files.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX  = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int SAMPLE_W = 16;
  localparam int MEDIAN_W = 16;
  localparam int SUM_W    = 48;
  localparam int CFG_W    = 9;

  localparam int VAL_W     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int AGE_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
  localparam int WCMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PFX_LVLS  = $clog2(WINDOW_MAX);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // One entry of the sorted window.
  typedef struct packed {
    logic             vld;
    logic [AGE_W-1:0] age;
    logic [VAL_W-1:0] val;
  } cell_t;

  // What a cell shows its neighbors: its entry and whether it sorts at or
  // below the incoming sample.
  typedef struct packed {
    cell_t st;
    logic  le;
  } cell_view_t;

endpackage

// ===== rtl/swm_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median: channel interfaces
// Valid/ready channels for samples, results and the window size register.
// ----------------------------------------------------------------------------
interface swm_sample_if;
  import swm_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swm_result_if;
  import swm_pkg::*;
  logic                valid;
  logic                ready;
  logic [MEDIAN_W-1:0] median;
  logic [SUM_W-1:0]    median_sum;
  modport source (output valid, output median, output median_sum, input ready);
  modport sink (input valid, input median, input median_sum, output ready);
endinterface

interface swm_cfg_if;
  import swm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_size;
  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

// ===== rtl/sliding_window_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median filter
// Lower median and saturating median sum over the last window_size samples.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while in_ready is high. Each
// sample enters a row of WINDOW_MAX sorter cells that keep the window in
// ascending order; on the beat every cell compares against the new
// sample, the oldest entry is dropped once the window is full and the new
// one is slotted in. The median is then read from the updated row and
// lands in the output register, so a result beat passes through the cell
// row and the output register after its sample beat. Output back-pressure
// stops intake only while a result is waiting both in the read stage and
// in the output register. Samples that leave the window short of full give
// no result. Writing window_size (0 is taken as 1, values above WINDOW_MAX
// as WINDOW_MAX) empties the window and zeroes the sum; the port is always
// ready and is meant to be written while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_median (
  input logic          clk,
  input logic          rst_n,
  swm_sample_if.sink   in_ch,
  swm_result_if.source out_ch,
  swm_cfg_if.sink      cfg_ch
);
  import swm_pkg::*;

  logic [CNT_W-1:0]    win_r;
  logic [AGE_W-1:0]    med_idx_r;
  logic [CNT_W-1:0]    fill_r;
  logic [CNT_W-1:0]    fill_nxt;
  logic                pend_r;
  logic [SUM_W-1:0]    sum_r;
  logic                out_valid_r;
  logic [MEDIAN_W-1:0] out_med_r;
  logic [SUM_W-1:0]    out_sum_r;

  logic                cfg_wr;
  logic [WCMP_W-1:0]   cfg_ext;
  logic [CNT_W-1:0]    win_cfg;
  logic                out_load;
  logic                in_ready;
  logic                in_acc;
  logic                evict_en;
  logic                produce;
  logic [VAL_W-1:0]    sample_val;
  logic [VAL_W-1:0]    med_val;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_sat;

  cell_view_t              views [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]   vic;
  logic [WINDOW_MAX-1:0]   pfx [PFX_LVLS+1];
  logic [WINDOW_MAX-1:0]   pre;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign cfg_ext      = WCMP_W'(cfg_ch.window_size);

  always_comb begin
    if (cfg_ext == '0) begin
      win_cfg = CNT_W'(1);
    end else if (cfg_ext > WCMP_W'(WINDOW_MAX)) begin
      win_cfg = CNT_W'(WINDOW_MAX);
    end else begin
      win_cfg = CNT_W'(cfg_ext);
    end
  end

  assign out_load    = !out_valid_r || out_ch.ready;
  assign in_ready    = !pend_r || out_load;
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign sample_val  = VAL_W'(in_ch.sample);

  assign evict_en = fill_r >= win_r;
  assign fill_nxt = evict_en ? fill_r : fill_r + CNT_W'(1);
  assign produce  = fill_nxt == win_r;

  // Inclusive prefix OR of the victim flags: a set bit means the victim sits
  // at or left of that cell, so the cell closes the gap from its right.
  always_comb begin
    pfx[0] = vic;
    for (int k = 0; k < PFX_LVLS; k++) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (i >= (1 << k)) begin
          pfx[k+1][i] = pfx[k][i] | pfx[k][i-(1<<k)];
        end else begin
          pfx[k+1][i] = pfx[k][i];
        end
      end
    end
  end

  assign pre = pfx[PFX_LVLS];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    cell_view_t left_v;
    cell_view_t right_v;
    logic       pre_left;

    if (i == 0) begin : g_first
      // The sample always sorts after the nonexistent left end.
      assign left_v   = '{st: '0, le: 1'b1};
      assign pre_left = 1'b0;
    end else begin : g_mid
      assign left_v   = views[i-1];
      assign pre_left = pre[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = views[i+1];
    end

    swm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (in_acc),
      .clear    (cfg_wr),
      .sample   (sample_val),
      .win      (win_r),
      .evict_en (evict_en),
      .left     (left_v),
      .right    (right_v),
      .pre_left (pre_left),
      .pre_self (pre[i]),
      .view     (views[i]),
      .victim   (vic[i])
    );
  end

  assign med_val = views[med_idx_r].st.val;
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(med_val);
  assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= CNT_W'(1);
      med_idx_r <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
    end else if (cfg_wr) begin
      win_r     <= win_cfg;
      med_idx_r <= AGE_W'((win_cfg - CNT_W'(1)) >> 1);
      fill_r    <= '0;
      sum_r     <= '0;
    end else begin
      if (in_acc) begin
        fill_r <= fill_nxt;
      end
      if (pend_r && out_load) begin
        sum_r <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_r <= produce;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (pend_r && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_load) begin
      out_med_r <= MEDIAN_W'(med_val);
      out_sum_r <= sum_sat;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.median     = out_med_r;
  assign out_ch.median_sum = out_sum_r;

endmodule

// ===== rtl/swm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median: sorter cell
// Holds one entry of the sorted window. On each sample it closes the gap left
// by the evicted entry and opens a slot for the new one, looking at its two
// neighbors and the victim prefix flags.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     clear,
  input  logic [swm_pkg::VAL_W-1:0] sample,
  input  logic [swm_pkg::CNT_W-1:0] win,
  input  logic                     evict_en,
  input  swm_pkg::cell_view_t      left,
  input  swm_pkg::cell_view_t      right,
  input  logic                     pre_left,
  input  logic                     pre_self,
  output swm_pkg::cell_view_t      view,
  output logic                     victim
);
  import swm_pkg::*;

  cell_t st_r;
  cell_t st_nxt;
  logic  le_own;
  cell_t c_self;
  cell_t c_left;
  logic  c_self_le;
  logic  c_left_le;

  assign le_own = st_r.vld && (st_r.val <= sample);
  assign victim = evict_en && st_r.vld && ((CNT_W'(st_r.age) + CNT_W'(1)) >= win);
  assign view   = '{st: st_r, le: le_own};

  // Window after eviction: cells at or past the victim take their right neighbor.
  always_comb begin
    c_self    = pre_self ? right.st : st_r;
    c_self_le = pre_self ? right.le : le_own;
    c_left    = pre_left ? st_r : left.st;
    c_left_le = pre_left ? le_own : left.le;
  end

  always_comb begin
    if (!c_self_le && c_left_le) begin
      st_nxt = '{vld: 1'b1, age: '0, val: sample};
    end else if (!c_self_le) begin
      st_nxt = '{vld: c_left.vld, age: c_left.age + AGE_W'(1), val: c_left.val};
    end else begin
      st_nxt = '{vld: c_self.vld, age: c_self.age + AGE_W'(1), val: c_self.val};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (clear) begin
      st_r.vld <= 1'b0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/swm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median: port checker
// Watches the top level's ports for timing and value rules of the block.
// ----------------------------------------------------------------------------
`include "sliding_window_median_macros.svh"

module swm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [swm_pkg::MEDIAN_W-1:0] median,
  input logic [swm_pkg::SUM_W-1:0]    median_sum
);

  // A stalled result beat keeps its payload.
  `SWM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(median) && $stable(median_sum), "result beat changed while stalled")

  // With the output register empty nothing can block intake.
  `SWM_ASSERT(a_in_ready_when_empty, !out_valid |-> in_ready, "sample refused with empty output")

  // A rising result beat comes from a sample beat that passed the cell row and then the output register.
  `SWM_ASSERT(a_result_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result beat without a sample two cycles earlier")

  // The running sum already holds the median it is delivered with.
  `SWM_ASSERT(a_sum_covers_median, out_valid |-> median_sum >= 48'(median), "median sum below its own median")

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .median     (out_ch.median),
  .median_sum (out_ch.median_sum)
);
